// ===== hw/rtl/bec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_pkg: shared types and constants of the button event conditioner
// Transaction payload structs, configuration register indexes, defaults.
// ----------------------------------------------------------------------------
package bec_pkg;

  // Parameter defaults
  localparam int NumButtonsDef = 6;
  localparam int TimeBitsDef   = 64;

  // Fixed payload field widths
  localparam int PinW     = 6;
  localparam int BtnW     = 3;
  localparam int TimeW    = 64;
  localparam int MaskW    = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int MaskPosW = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeat   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMask     = 2'd2;

  // Register reset values
  localparam logic [CfgDataW-1:0] DebounceRst = 32'd50000;
  localparam logic [CfgDataW-1:0] RepeatRst   = 32'd500000;
  localparam logic [MaskW-1:0]    MaskRst     = 12'd0;

  // Request kinds
  localparam logic ReqEdge = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [BtnW-1:0]  edge_button;
    logic [PinW-1:0]  pin_levels;
    logic [TimeW-1:0] now_us;
  } bec_in_t;

  typedef struct packed {
    logic             is_release;
    logic [BtnW-1:0]  event_button;
    logic [PinW-1:0]  hold_set;
    logic [TimeW-1:0] event_time_us;
    logic             repeated;
    logic [TimeW-1:0] held_duration_us;
    logic             last;
  } bec_out_t;

endpackage

// ===== hw/rtl/bec_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_alu: shared adder and time compare
// Forms a + b + cin one bit wider than the time and flags sum <= now.
// ----------------------------------------------------------------------------
module bec_alu #(
  parameter int TIME_BITS = 64
) (
  input  logic [TIME_BITS-1:0] a_i,
  input  logic [TIME_BITS-1:0] b_i,
  input  logic                 cin_i,
  input  logic [TIME_BITS-1:0] now_i,
  output logic [TIME_BITS:0]   sum_o,
  output logic                 reach_o
);

  // Keep the carry so that base + delay is compared without wrap
  assign sum_o   = {1'b0, a_i} + {1'b0, b_i} + {{TIME_BITS{1'b0}}, cin_i};
  assign reach_o = (sum_o <= {1'b0, now_i});

endmodule

// ===== hw/rtl/bec_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_store: per-button timestamp registers
// Last accepted event time per button and edge, and press start per button.
// ----------------------------------------------------------------------------
module bec_store #(
  parameter int NUM_BUTTONS = 6,
  parameter int TIME_BITS   = 64,
  parameter int IdxW        = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IdxW:0]        la_idx_i,
  input  logic                 la_we_i,
  input  logic [IdxW-1:0]      ps_idx_i,
  input  logic                 ps_we_i,
  input  logic [TIME_BITS-1:0] wr_data_i,
  output logic [TIME_BITS-1:0] la_rd_o,
  output logic [TIME_BITS-1:0] ps_rd_o
);

  logic [TIME_BITS-1:0] last_acc_q [2*NUM_BUTTONS];
  logic [TIME_BITS-1:0] press_st_q [NUM_BUTTONS];

  assign la_rd_o = last_acc_q[la_idx_i];
  assign ps_rd_o = press_st_q[ps_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2*NUM_BUTTONS; i++) last_acc_q[i] <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) press_st_q[i] <= '0;
    end else begin
      if (la_we_i) last_acc_q[la_idx_i] <= wr_data_i;
      if (ps_we_i) press_st_q[ps_idx_i] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/button_event_conditioner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_conditioner: debounce and auto-repeat for active-low buttons
// Turns edge and tick requests into press/release events through one shared
// adder-compare unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+------------------------
//  in       | input     | in_valid_i/in_stall_o   | bec_in_t  (request)
//  out      | output    | out_valid_o/out_stall_i | bec_out_t (event)
//  cfg      | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// Steps (accept to next accept): a dropped edge passes idle and check, an
//   accepted press idle, check and emit, and a release also a duration
//   step, one more pass through the adder for the held duration.
//   A tick passes idle, then walks the buttons with a debounce and a
//   repeat step per held button and a debounce step per released one,
//   then scans the buttons up to the last repeating one, with an emit per
//   event, and a closing step.
// Reset: asynchronous, active low; clears all timestamps to zero and loads
//   the register defaults.
// Stalls: the output register holds one event; the sequencer waits while it
//   is full and stalled, and a new request is taken while an event waits.
// ----------------------------------------------------------------------------
module button_event_conditioner #(
  parameter int NUM_BUTTONS = bec_pkg::NumButtonsDef,
  parameter int TIME_BITS   = bec_pkg::TimeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bec_pkg::bec_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bec_pkg::bec_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bec_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bec_pkg::CfgDataW-1:0]   cfg_data_i
);

  import bec_pkg::*;

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EDGE_CHK = 3'd1;
  localparam logic [2:0] S_EDGE_DUR = 3'd2;
  localparam logic [2:0] S_TICK_DB  = 3'd3;
  localparam logic [2:0] S_TICK_RP  = 3'd4;
  localparam logic [2:0] S_TICK_OUT = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;

  // Configuration registers
  logic [CfgDataW-1:0] debounce_q, repeat_q;
  logic [MaskW-1:0]    mask_q;

  // Request context
  logic [2:0]             state_q, state_d;
  logic                   is_tick_q;
  logic [BtnW-1:0]        btn_q;
  logic [NUM_BUTTONS-1:0] hold_q, hold_in;
  logic [TIME_BITS-1:0]   now_q;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic                   ok_q, ok_d;
  logic [NUM_BUTTONS-1:0] qual_q, qual_d;
  bec_out_t               res_q, res_d;

  // Output register
  bec_out_t out_q;
  logic     out_valid_q;
  logic     out_free;

  // Shared unit and store hookup
  logic [TIME_BITS-1:0] alu_a, alu_b, la_rd, ps_rd;
  logic                 alu_cin, alu_reach;
  logic [TIME_BITS:0]   alu_sum;
  logic [IdxW:0]        la_idx;
  logic [IdxW-1:0]      ps_idx, bidx;
  logic                 la_we, ps_we;

  // Edge decode
  logic                 btn_ok, pressed, masked;
  logic [MaskPosW-1:0]  mask_pos;
  logic [TIME_BITS-1:0] deb_ext, rep_ext;
  logic                 in_acc, idx_end;
  logic [PinW-1:0]      hold_out;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign deb_ext = TIME_BITS'(debounce_q);
  assign rep_ext = TIME_BITS'(repeat_q);

  // Buttons beyond the pin field read as held (inverted zero-extension)
  assign hold_in  = NUM_BUTTONS'(~{{NUM_BUTTONS{1'b0}}, in_data_i.pin_levels});
  assign hold_out = PinW'({{PinW{1'b0}}, hold_q});

  assign bidx    = IdxW'(btn_q);
  assign idx_end = (idx_q == IdxW'(NUM_BUTTONS - 1));

  always_comb begin
    btn_ok  = 1'b0;
    pressed = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (btn_q == BtnW'(i)) begin
        btn_ok  = 1'b1;
        pressed = hold_q[i];
      end
    end
    // Press masks sit at the button index, release masks one bank higher
    mask_pos = MaskPosW'(btn_q) + (pressed ? '0 : MaskPosW'(NUM_BUTTONS));
    masked   = 1'b0;
    for (int k = 0; k < MaskW; k++) begin
      if (mask_pos == MaskPosW'(k)) masked = mask_q[k];
    end
  end

  // Steer the store ports: ticks walk the counter, edges use the named slot
  assign la_idx = is_tick_q ? {idx_q, 1'b0} : {bidx, ~pressed};
  assign ps_idx = is_tick_q ? idx_q : bidx;

  // Steer the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (state_q) inside
      S_EDGE_CHK, S_TICK_DB: begin
        alu_a = la_rd;
        alu_b = deb_ext;
      end
      S_EDGE_DUR: begin
        alu_a   = now_q;
        alu_b   = ~ps_rd;
        alu_cin = 1'b1;
      end
      S_TICK_RP: begin
        alu_a = ps_rd;
        alu_b = rep_ext;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  bec_alu #(
    .TIME_BITS(TIME_BITS)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .cin_i  (alu_cin),
    .now_i  (now_q),
    .sum_o  (alu_sum),
    .reach_o(alu_reach)
  );

  bec_store #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .TIME_BITS  (TIME_BITS),
    .IdxW       (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .la_idx_i (la_idx),
    .la_we_i  (la_we),
    .ps_idx_i (ps_idx),
    .ps_we_i  (ps_we),
    .wr_data_i(now_q),
    .la_rd_o  (la_rd),
    .ps_rd_o  (ps_rd)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ok_d    = ok_q;
    qual_d  = qual_q;
    res_d   = res_q;
    la_we   = 1'b0;
    ps_we   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.req_type == ReqTick) ? S_TICK_DB : S_EDGE_CHK;
          idx_d   = '0;
          qual_d  = '0;
        end
      end

      // Drop out-of-range, masked or bouncing edges; record the rest
      S_EDGE_CHK: begin
        if (!btn_ok || masked || !alu_reach) begin
          state_d = S_IDLE;
        end else begin
          la_we = 1'b1;
          res_d.is_release       = ~pressed;
          res_d.event_button     = btn_q;
          res_d.hold_set         = hold_out;
          res_d.event_time_us    = TimeW'(now_q);
          res_d.repeated         = 1'b0;
          res_d.held_duration_us = '0;
          res_d.last             = 1'b1;
          if (pressed) begin
            ps_we   = 1'b1;
            state_d = S_EMIT;
          end else begin
            state_d = S_EDGE_DUR;
          end
        end
      end

      // Measure the hold as now - press start, modulo the time width
      S_EDGE_DUR: begin
        res_d.held_duration_us = TimeW'(alu_sum[TIME_BITS-1:0]);
        state_d = S_EMIT;
      end

      // Debounce check of a held button; skip released ones
      S_TICK_DB: begin
        if (hold_q[idx_q]) begin
          ok_d    = alu_reach;
          state_d = S_TICK_RP;
        end else if (idx_end) begin
          idx_d   = '0;
          state_d = S_TICK_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Repeat delay check; mark and stamp qualifying buttons
      S_TICK_RP: begin
        if (ok_q && alu_reach) begin
          qual_d[idx_q] = 1'b1;
          la_we         = 1'b1;
        end
        if (idx_end) begin
          idx_d   = '0;
          state_d = S_TICK_OUT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_TICK_DB;
        end
      end

      // Emit marked buttons in ascending order; last when none remain
      S_TICK_OUT: begin
        if (qual_q == '0) begin
          state_d = S_IDLE;
        end else begin
          if (qual_q[idx_q]) begin
            qual_d[idx_q]          = 1'b0;
            res_d.is_release       = 1'b0;
            res_d.event_button     = BtnW'(idx_q);
            res_d.hold_set         = hold_out;
            res_d.event_time_us    = TimeW'(now_q);
            res_d.repeated         = 1'b1;
            res_d.held_duration_us = '0;
            res_d.last             = (qual_d == '0);
            state_d                = S_EMIT;
          end
          idx_d = idx_q + 1'b1;
        end
      end

      // Hand the event to the output register once it has room
      S_EMIT: begin
        if (out_free) state_d = is_tick_q ? S_TICK_OUT : S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ok_q        <= 1'b0;
      qual_q      <= '0;
      debounce_q  <= DebounceRst;
      repeat_q    <= RepeatRst;
      mask_q      <= MaskRst;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ok_q    <= ok_d;
      qual_q  <= qual_d;

      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgDebounce: debounce_q <= cfg_data_i;
          CfgRepeat:   repeat_q   <= cfg_data_i;
          CfgMask:     mask_q     <= cfg_data_i[MaskW-1:0];
          default:     ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_acc) begin
      is_tick_q <= (in_data_i.req_type == ReqTick);
      btn_q     <= in_data_i.edge_button;
      hold_q    <= hold_in;
      now_q     <= in_data_i.now_us[TIME_BITS-1:0];
    end
    if (state_q == S_EMIT && out_free) out_q <= res_q;
  end

endmodule
